// ===== hw/rtl/scbs_pkg.sv =====
// scbs_pkg: shared types and constants for the sample consensus background subtractor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package scbs_pkg;

  // image geometry and samples per pixel
  localparam int unsigned ImgW = 640;
  localparam int unsigned ImgH = 480;
  localparam int unsigned NumSamples = 20;

  // configuration register indexes
  localparam logic [2:0] RegWidth  = 3'd0;
  localparam logic [2:0] RegHeight = 3'd1;
  localparam logic [2:0] RegRadius = 3'd2;
  localparam logic [2:0] RegMinM   = 3'd3;
  localparam logic [2:0] RegSubLog = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_WRITE,
    ST_NBR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [9:0]  frame_width;
    logic [8:0]  frame_height;
    logic [17:0] radius_sq;
    logic [4:0]  min_matches;
    logic [3:0]  subsample_log2;
  } cfg_t;

  // squared distance of two colours, 18 bits suffice for 3*255^2
  function automatic logic [17:0] col_dist(input logic [23:0] a, input logic [23:0] b);
    logic [7:0]  dr, dg, db;
    logic [15:0] sr, sg, sb;
    begin
      dr = (a[23:16] > b[23:16]) ? a[23:16] - b[23:16] : b[23:16] - a[23:16];
      dg = (a[15:8] > b[15:8]) ? a[15:8] - b[15:8] : b[15:8] - a[15:8];
      db = (a[7:0] > b[7:0]) ? a[7:0] - b[7:0] : b[7:0] - a[7:0];
      sr = dr * dr;
      sg = dg * dg;
      sb = db * db;
      col_dist = {2'b00, sr} + {2'b00, sg} + {2'b00, sb};
    end
  endfunction

  // draw hits when the low subsample_log2 bits are zero
  function automatic logic draw_hit(input logic [7:0] d, input logic [3:0] lg);
    logic [15:0] m;
    begin
      m = (16'd1 << lg) - 16'd1;
      draw_hit = (d & m[7:0]) == 8'd0;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/scbs_cfg.sv =====
// scbs_cfg: configuration register bank with reset values
// depends on scbs_pkg
`timescale 1ns / 1ps
`default_nettype none
module scbs_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  output scbs_pkg::cfg_t     cfg
);
  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width    <= 10'd640;
      cfg.frame_height   <= 9'd480;
      cfg.radius_sq      <= 18'd400;
      cfg.min_matches    <= 5'd2;
      cfg.subsample_log2 <= 4'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        scbs_pkg::RegWidth:  cfg.frame_width    <= cfg_data[9:0];
        scbs_pkg::RegHeight: cfg.frame_height   <= cfg_data[8:0];
        scbs_pkg::RegRadius: cfg.radius_sq      <= cfg_data[17:0];
        scbs_pkg::RegMinM:   cfg.min_matches    <= cfg_data[4:0];
        scbs_pkg::RegSubLog: cfg.subsample_log2 <= cfg_data[3:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/sample_consensus_background_subtractor_unit.sv =====
// top level: pixel model stores, scan sequencer and result register
// depends on scbs_pkg and scbs_cfg
//
// channel  direction  fields
// s_axis   in         tdata: x_pos,y_pos,red,green,blue,self_draw,self_slot,
//                     neighbor_draw,neighbor_slot,neighbor_dir; tuser: mode
// m_axis   out        tdata: match_count,bg_red,bg_green,bg_blue; tuser: foreground
// cfg      in         index, data
//
// one request at a time; a request passes the read, write, neighbour and output
// states, plus a scan after read for classify requests inside the frame with
// nonzero min_matches, one sample per cycle (at most NumSamples, stopping at
// min_matches). the next request is taken in the cycle after the result leaves.
// stores have no reset and are valid only after init writes; rst clears the
// sequencer and the registers. Input is held off while a result is pending.
`timescale 1ns / 1ps
`default_nettype none
module sample_consensus_background_subtractor_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // x_pos[9:0] y_pos[18:10] red[26:19] green[34:27] blue[42:35] self_draw[50:43]
  // self_slot[55:51] neighbor_draw[63:56] neighbor_slot[68:64] neighbor_dir[71:69]
  input  wire logic [71:0] s_axis_tdata,
  // mode
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // match_count[4:0] bg_red[12:5] bg_green[20:13] bg_blue[28:21]
  output logic [31:0]      m_axis_tdata,
  // foreground
  output logic             m_axis_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int unsigned NPix = scbs_pkg::ImgW * scbs_pkg::ImgH;
  localparam int unsigned PixW = $clog2(NPix);
  localparam int unsigned SlotW = $clog2(scbs_pkg::NumSamples);
  localparam int unsigned SAddrW = $clog2(NPix * scbs_pkg::NumSamples);

  scbs_pkg::cfg_t cfg;
  scbs_cfg u_cfg (.clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg);

  scbs_pkg::state_t state, state_next;

  // captured request
  logic        mode;
  logic [9:0]  x;
  logic [8:0]  y;
  logic [23:0] colour;
  logic [7:0]  sdraw, ndraw;
  logic [4:0]  sslot, nslot;
  logic [2:0]  ndir;
  logic        inside_frame;
  logic [PixW-1:0] pix;
  logic [4:0]  count;
  logic [SlotW-1:0] k;
  logic [SlotW-1:0] k_rd;
  logic [9:0]  nx;
  logic [8:0]  ny;

  // memories
  logic [23:0] sample_mem [NPix*scbs_pkg::NumSamples];
  logic [23:0] bg_mem [NPix];
  logic [23:0] s_rd, bg_rd;
  logic        s_we, bg_we;
  logic [SAddrW-1:0] s_addr;
  logic [SAddrW-1:0] s_waddr;
  logic [PixW-1:0]   bg_addr;

  // clamped frame size
  logic [12:0] w_c, h_c;
  always_comb begin
    w_c = {3'd0, cfg.frame_width};
    h_c = {4'd0, cfg.frame_height};
    if (w_c < 13'd2) w_c = 13'd2;
    if (w_c > 13'(scbs_pkg::ImgW)) w_c = 13'(scbs_pkg::ImgW);
    if (h_c < 13'd2) h_c = 13'd2;
    if (h_c > 13'(scbs_pkg::ImgH)) h_c = 13'(scbs_pkg::ImgH);
  end

  // frame test and pixel index of the held request
  assign inside_frame = ({3'd0, x} < w_c) && ({4'd0, y} < h_c);
  assign pix = PixW'(y * scbs_pkg::ImgW + x);

  // neighbour coordinates mirrored at borders
  logic signed [2:0] dx, dy;
  always_comb begin
    case (ndir)
      3'd0, 3'd3, 3'd5: dx = -3'sd1;
      3'd2, 3'd4, 3'd7: dx = 3'sd1;
      default:          dx = 3'sd0;
    endcase
    case (ndir)
      3'd0, 3'd1, 3'd2: dy = -3'sd1;
      3'd5, 3'd6, 3'd7: dy = 3'sd1;
      default:          dy = 3'sd0;
    endcase
    if (x == 10'd0 && dx < 0) dx = 3'sd1;
    if ({3'd0, x} == w_c - 13'd1 && dx > 0) dx = -3'sd1;
    if (y == 9'd0 && dy < 0) dy = 3'sd1;
    if ({4'd0, y} == h_c - 13'd1 && dy > 0) dy = -3'sd1;
  end

  logic [PixW-1:0] npix;
  logic hit_s, hit_n, bg_ok;
  logic [17:0] col_d;
  always_comb begin
    hit_s = scbs_pkg::draw_hit(sdraw, cfg.subsample_log2);
    hit_n = scbs_pkg::draw_hit(ndraw, cfg.subsample_log2);
    bg_ok = count >= cfg.min_matches;
    col_d = scbs_pkg::col_dist(colour, s_rd);
    npix  = PixW'(ny * scbs_pkg::ImgW + nx);
  end

  assign s_axis_tready = (state == scbs_pkg::ST_IDLE);

  // memory ports; the scan reads one sample ahead of the compare
  always_comb begin
    s_we = 1'b0;
    bg_we = 1'b0;
    s_waddr = SAddrW'(pix * scbs_pkg::NumSamples + sslot);
    bg_addr = pix;
    case (state)
      scbs_pkg::ST_WRITE: begin
        if (inside_frame) begin
          if (!mode) begin
            s_we  = sslot < 5'(scbs_pkg::NumSamples);
            bg_we = sslot == 5'd0;
          end else if (bg_ok && hit_s) begin
            s_we  = sslot < 5'(scbs_pkg::NumSamples);
            bg_we = 1'b1;
          end
        end
      end
      scbs_pkg::ST_NBR: begin
        s_waddr = SAddrW'(npix * scbs_pkg::NumSamples + nslot);
        s_we = inside_frame && mode && bg_ok && hit_n &&
               nslot < 5'(scbs_pkg::NumSamples);
      end
      default: ;
    endcase
    k_rd = (state == scbs_pkg::ST_SCAN) ? k + SlotW'(1) : k;
    s_addr = SAddrW'(pix * scbs_pkg::NumSamples + k_rd);
  end

  always_ff @(posedge clk) begin
    if (s_we) sample_mem[s_waddr] <= colour;
    s_rd <= sample_mem[s_addr];
  end

  always_ff @(posedge clk) begin
    if (bg_we) bg_mem[bg_addr] <= colour;
    bg_rd <= bg_mem[bg_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      scbs_pkg::ST_IDLE:  if (s_axis_tvalid) state_next = scbs_pkg::ST_READ;
      scbs_pkg::ST_READ:  state_next = (inside_frame && mode && cfg.min_matches != 5'd0)
                                       ? scbs_pkg::ST_SCAN : scbs_pkg::ST_WRITE;
      scbs_pkg::ST_SCAN: begin
        if ((col_d < cfg.radius_sq && count + 5'd1 >= cfg.min_matches) ||
            k == SlotW'(scbs_pkg::NumSamples - 1))
          state_next = scbs_pkg::ST_WRITE;
      end
      scbs_pkg::ST_WRITE: state_next = scbs_pkg::ST_NBR;
      scbs_pkg::ST_NBR:   state_next = scbs_pkg::ST_OUT;
      scbs_pkg::ST_OUT:   if (m_axis_tready) state_next = scbs_pkg::ST_IDLE;
      default:            state_next = scbs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= scbs_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 5'd0;
      k <= '0;
    end else begin
      case (state)
        scbs_pkg::ST_IDLE: if (s_axis_tvalid) begin
          x      <= s_axis_tdata[9:0];
          y      <= s_axis_tdata[18:10];
          colour <= s_axis_tdata[42:19];
          sdraw  <= s_axis_tdata[50:43];
          sslot  <= s_axis_tdata[55:51];
          ndraw  <= s_axis_tdata[63:56];
          nslot  <= s_axis_tdata[68:64];
          ndir   <= s_axis_tdata[71:69];
          mode   <= s_axis_tuser;
          count  <= 5'd0;
          k      <= '0;
        end
        scbs_pkg::ST_READ: begin
          nx <= 10'(x + 10'(dx));
          ny <= 9'(y + 9'(dy));
        end
        scbs_pkg::ST_SCAN: begin
          if (col_d < cfg.radius_sq) count <= count + 5'd1;
          k <= k + SlotW'(1);
        end
        default: ;
      endcase
    end
  end

  // output: background is read in the cycle after its write
  logic [23:0] bg_out;
  assign bg_out = inside_frame ? bg_rd : 24'd0;
  assign m_axis_tvalid = (state == scbs_pkg::ST_OUT);
  assign m_axis_tuser = inside_frame && mode && !bg_ok;
  assign m_axis_tdata = {3'd0, bg_out[23:16], bg_out[15:8], bg_out[7:0],
                         inside_frame ? count : 5'd0};
endmodule
`default_nettype wire

// ===== tb/tb_sample_consensus_background_subtractor_unit.sv =====
// testbench for the sample consensus background subtractor: pixel requests are checked
// against an in-bench pixel model with its own sample and background stores
// depends on scbs_pkg and the sample_consensus_background_subtractor_unit rtl
`timescale 1ns / 1ps
module tb_sample_consensus_background_subtractor_unit;

  localparam int unsigned ImgW = 640;
  localparam int unsigned ImgH = 480;
  localparam int unsigned NSmp = 20;
  localparam int unsigned CycleLimit = 600000;
  localparam logic ModeInit = 1'b0;
  localparam logic ModeClassify = 1'b1;

  typedef struct {
    logic       mode;
    logic [9:0] x;
    logic [8:0] y;
    logic [7:0] r, g, b;
    logic [7:0] sdraw;
    logic [4:0] sslot;
    logic [7:0] ndraw;
    logic [4:0] nslot;
    logic [2:0] ndir;
  } pixel_t;

  typedef struct {
    logic       fg;
    logic [4:0] cnt;
    logic [7:0] r, g, b;
  } verdict_t;

  typedef struct {
    bit       known;
    pixel_t   px;
    verdict_t v;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sample_consensus_background_subtractor_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // model state
  logic [23:0] smp_mem[int unsigned];
  logic [23:0] bg_mem[int unsigned];
  int unsigned ready_pix[$];
  int unsigned fw = 640, fh = 480, rad = 400, minm = 2, sublg = 4;

  verdict_t pending[$];
  int errors = 0;
  int unsigned cycles = 0;
  bit idle_on = 1'b1;
  int stall_cnt = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic bit draw_ok(logic [7:0] d);
    int unsigned mask;
    mask = (32'd1 << sublg) - 1;
    return (d & mask) == 0;
  endfunction

  function automatic int unsigned sq_dist(logic [23:0] a, logic [23:0] c);
    int unsigned acc;
    int dd;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      dd = int'(a[8*i +: 8]) - int'(c[8*i +: 8]);
      acc += dd * dd;
    end
    return acc;
  endfunction

  // classify or seed one pixel, updating the model stores
  function automatic verdict_t predict_pixel(pixel_t p);
    verdict_t v;
    int unsigned w, h, pix, k, nx, ny;
    int dx, dy;
    logic [23:0] col, bgc;
    v = '{default: '0};
    w = fw < 2 ? 2 : (fw > ImgW ? ImgW : fw);
    h = fh < 2 ? 2 : (fh > ImgH ? ImgH : fh);
    if (p.x >= w || p.y >= h) return v;
    pix = p.y * ImgW + p.x;
    col = {p.r, p.g, p.b};
    if (p.mode == ModeInit) begin
      if (p.sslot < NSmp) begin
        smp_mem[pix * NSmp + p.sslot] = col;
        if (p.sslot == 0) bg_mem[pix] = col;
      end
    end else begin
      k = 0;
      while (k < NSmp && v.cnt < minm) begin
        if (sq_dist(col, smp_mem[pix * NSmp + k]) < rad) v.cnt++;
        k++;
      end
      if (v.cnt < minm) begin
        v.fg = 1'b1;
      end else begin
        if (draw_ok(p.sdraw)) begin
          if (p.sslot < NSmp) smp_mem[pix * NSmp + p.sslot] = col;
          bg_mem[pix] = col;
        end
        if (draw_ok(p.ndraw)) begin
          dx = (p.ndir == 0 || p.ndir == 3 || p.ndir == 5) ? -1 :
               (p.ndir == 1 || p.ndir == 6) ? 0 : 1;
          dy = p.ndir < 3 ? -1 : (p.ndir < 5 ? 0 : 1);
          if (p.x == 0 && dx < 0) dx = 1;
          if (p.x == w - 1 && dx > 0) dx = -1;
          if (p.y == 0 && dy < 0) dy = 1;
          if (p.y == h - 1 && dy > 0) dy = -1;
          nx = p.x + dx;
          ny = p.y + dy;
          if (p.nslot < NSmp) smp_mem[(ny * ImgW + nx) * NSmp + p.nslot] = col;
        end
      end
    end
    bgc = bg_mem[pix];
    {v.r, v.g, v.b} = bgc;
    return v;
  endfunction

  // send one pixel request; the model runs on acceptance
  task automatic send_pixel(pixel_t p, bit known, verdict_t v);
    verdict_t want;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= p.mode;
    s_axis_tdata <= {p.ndir, p.nslot, p.ndraw, p.sslot, p.sdraw, p.b, p.g, p.r, p.y, p.x};
    do @(posedge clk); while (!s_axis_tready);
    want = predict_pixel(p);
    if (known) pending.push_back(v);
    else pending.push_back(want);
  endtask

  // drain results, then write all registers
  task automatic set_regs(int unsigned w, int unsigned h, int unsigned rq,
                          int unsigned mm, int unsigned sl);
    int unsigned vals[5];
    logic [2:0] idx[5];
    vals = '{w, h, rq, mm, sl};
    idx = '{scbs_pkg::RegWidth, scbs_pkg::RegHeight, scbs_pkg::RegRadius,
            scbs_pkg::RegMinM, scbs_pkg::RegSubLog};
    s_axis_tvalid <= 1'b0;
    wait (pending.size() == 0);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    fw = w & 10'h3FF;
    fh = h & 9'h1FF;
    rad = rq & 18'h3FFFF;
    minm = mm & 5'h1F;
    sublg = sl & 4'hF;
  endtask

  function automatic pixel_t rand_pixel(logic m, int unsigned x, int unsigned y);
    pixel_t p;
    p.mode = m;
    p.x = 10'(x);
    p.y = 9'(y);
    p.r = 8'($urandom_range(0, 255));
    p.g = 8'($urandom_range(0, 255));
    p.b = 8'($urandom_range(0, 255));
    p.sdraw = 8'($urandom_range(0, 255));
    p.sslot = 5'($urandom_range(0, 31));
    p.ndraw = 8'($urandom_range(0, 255));
    p.nslot = 5'($urandom_range(0, 31));
    p.ndir = 3'($urandom_range(0, 7));
    return p;
  endfunction

  function automatic logic [7:0] jitter(logic [7:0] c, int amt);
    int t;
    t = int'(c) + $urandom_range(0, 2 * amt) - amt;
    return t < 0 ? 8'd0 : (t > 255 ? 8'd255 : t[7:0]);
  endfunction

  // one random phase over the seeded pixels inside the frame, with one request in ten outside it
  task automatic random_phase(int n);
    int unsigned w, h, pix, k;
    int unsigned live[$];
    pixel_t p;
    logic [23:0] s;
    verdict_t none;
    none = '{default: '0};
    w = fw < 2 ? 2 : (fw > ImgW ? ImgW : fw);
    h = fh < 2 ? 2 : (fh > ImgH ? ImgH : fh);
    foreach (ready_pix[i])
      if (ready_pix[i] % ImgW < w && ready_pix[i] / ImgW < h) live.push_back(ready_pix[i]);
    for (int i = 0; i < n; i++) begin
      pix = live[$urandom_range(0, live.size() - 1)];
      k = $urandom_range(0, 9);
      if (k < 1) begin
        // outside the active frame
        if ($urandom_range(0, 1)) p = rand_pixel(1'($urandom_range(0, 1)),
                                                 $urandom_range(w, 1023),
                                                 $urandom_range(0, 511));
        else p = rand_pixel(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                            $urandom_range(h, 511));
      end else if (k < 2) begin
        p = rand_pixel(ModeInit, pix % ImgW, pix / ImgW);
      end else begin
        p = rand_pixel(ModeClassify, pix % ImgW, pix / ImgW);
        if (k < 8) begin
          // colour close to one of the stored samples
          s = smp_mem[pix * NSmp + $urandom_range(0, NSmp - 1)];
          p.r = jitter(s[23:16], 12);
          p.g = jitter(s[15:8], 12);
          p.b = jitter(s[7:0], 12);
        end
      end
      send_pixel(p, 1'b0, none);
    end
  endtask

  // result checking and downstream stalls
  initial begin
    verdict_t e;
    logic [4:0] gc;
    logic [7:0] gr, gg, gb;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        {gb, gg, gr, gc} = m_axis_tdata[28:0];
        if (pending.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h fg %b", m_axis_tdata, m_axis_tuser);
        end else begin
          e = pending.pop_front();
          if (e.fg !== m_axis_tuser || e.cnt !== gc || e.r !== gr || e.g !== gg ||
              e.b !== gb) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp fg %b cnt %0d bg %h%h%h, got fg %b cnt %0d bg %h%h%h",
                       e.fg, e.cnt, e.r, e.g, e.b, m_axis_tuser, gc, gr, gg, gb);
          end
        end
      end
      if (stall_cnt > 0) stall_cnt--;
      else if (idle_on && $urandom_range(0, 7) == 0) stall_cnt = $urandom_range(1, 17);
      m_axis_tready <= (stall_cnt == 0);
    end
  end

  // stimulus
  initial begin
    row_t rows[$];
    pixel_t p;
    verdict_t z, none;
    logic [23:0] base;
    int unsigned xs[$], ys[$];
    z = '{default: '0};
    none = z;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // seed corner regions of the frame, slot 0 first so the background is set
    for (int y = 0; y < 4; y++)
      for (int x = 0; x < 4; x++) begin
        xs.push_back(x);
        ys.push_back(y);
      end
    for (int y = 478; y < 480; y++)
      for (int x = 638; x < 640; x++) begin
        xs.push_back(x);
        ys.push_back(y);
      end
    foreach (xs[i]) begin
      base = 24'($urandom);
      for (int sl = 0; sl < NSmp; sl++) begin
        p = rand_pixel(ModeInit, xs[i], ys[i]);
        p.sslot = 5'(sl);
        p.r = jitter(base[23:16], 20);
        p.g = jitter(base[15:8], 20);
        p.b = jitter(base[7:0], 20);
        send_pixel(p, 1'b0, none);
      end
      ready_pix.push_back(ys[i] * ImgW + xs[i]);
    end

    // directed rows at reset register values
    p = rand_pixel(ModeClassify, 640, 0);
    rows.push_back('{1'b1, p, z});
    p = rand_pixel(ModeInit, 1023, 511);
    rows.push_back('{1'b1, p, z});
    p = rand_pixel(ModeClassify, 0, 480);
    rows.push_back('{1'b1, p, z});
    p = rand_pixel(ModeInit, 0, 0);
    p.sslot = 0; {p.r, p.g, p.b} = 24'h000000;
    rows.push_back('{1'b1, p, z});
    p = rand_pixel(ModeInit, 0, 0);
    p.sslot = 31; {p.r, p.g, p.b} = 24'hFFFFFF;
    rows.push_back('{1'b1, p, z});
    p = rand_pixel(ModeInit, 0, 0);
    p.sslot = 20; {p.r, p.g, p.b} = 24'hFFFFFF;
    rows.push_back('{1'b1, p, z});
    p = rand_pixel(ModeInit, 0, 0);
    p.sslot = 19; {p.r, p.g, p.b} = 24'hFFFFFF;
    rows.push_back('{1'b1, p, z});
    p = rand_pixel(ModeClassify, 0, 0);
    {p.r, p.g, p.b} = 24'h000000; p.sdraw = 8'hFF; p.ndraw = 8'hFF;
    rows.push_back('{1'b0, p, z});
    p = rand_pixel(ModeClassify, 0, 0);
    {p.r, p.g, p.b} = 24'hFFFFFF;
    rows.push_back('{1'b0, p, z});
    for (int d = 0; d < 8; d++) begin
      p = rand_pixel(ModeClassify, d < 4 ? 639 : 0, d < 4 ? 479 : 0);
      {p.sdraw, p.ndraw, p.ndir} = {16'h0000, 3'(d)};
      p.sslot = d[0] ? 5'd31 : 5'd3;
      rows.push_back('{1'b0, p, z});
    end
    p = rand_pixel(ModeClassify, 639, 478);
    {p.sdraw, p.ndraw, p.ndir, p.nslot} = {16'h0000, 3'd4, 5'd19};
    rows.push_back('{1'b0, p, z});
    p = rand_pixel(ModeClassify, 638, 479);
    {p.sdraw, p.ndraw, p.ndir, p.nslot} = {16'h0000, 3'd6, 5'd20};
    rows.push_back('{1'b0, p, z});
    foreach (rows[i]) begin
      if (rows[i].known && rows[i].px.mode == ModeInit && rows[i].px.x == 0 &&
          rows[i].px.y == 0) begin
        // seeding slot 0 with black sets the background to black
        rows[i].v = z;
      end
      send_pixel(rows[i].px, rows[i].known, rows[i].v);
    end

    // phases across register settings, extremes included
    random_phase(150);
    set_regs(2, 2, 0, 1, 0);
    random_phase(130);
    set_regs(4, 4, 195075, 20, 8);
    random_phase(130);
    // hold the sender until everything has drained, then carry on
    s_axis_tvalid <= 1'b0;
    wait (pending.size() == 0);
    set_regs(3, 1, $urandom_range(200, 3000), 0, 15);
    random_phase(120);
    set_regs(1023, 511, 262143, 31, 1);
    random_phase(120);
    set_regs(640, 480, $urandom_range(100, 2000), $urandom_range(1, 6), 2);
    random_phase(120);
    set_regs(0, 0, 900, 3, 1);
    idle_on = 1'b0;
    random_phase(200);

    s_axis_tvalid <= 1'b0;
    wait (pending.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
